>>> src/pbdc_pkg.sv
package pbdc_pkg;

    // Field widths of the input and result items.
    localparam int VALUE_W = 56;
    localparam int DIGIT_W = 2;

    // Weight registers hold the weight above the one being scanned, so they
    // need room for the Pell weight one past the top index and for twice a weight.
    localparam int WT_W = 59;

    // Default number of Pell weights scanned per item.
    localparam int NUM_DIGITS_DEF = 45;

    // Digit codes.
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 2'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 2'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_TWO  = 2'd2;

    typedef logic [WT_W-1:0] t_weight;

    // Pell weight at the given index (1, 2, 5, 12, ...). This is only ever
    // called with constant arguments, so it is evaluated at elaboration.
    function automatic t_weight pell_weight(input int idx);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] nx;
        lo = 64'd1;
        hi = 64'd2;
        for (int k = 0; k < 64; k++) begin
            if (k < idx) begin
                nx = (hi << 1) + lo;
                lo = hi;
                hi = nx;
            end
        end
        return lo[WT_W-1:0];
    endfunction

endpackage

>>> src/pell_base_digit_converter_top.sv
// The shared compare and subtract unit scans one weight per cycle from input accept until
// the last digit is shown at o_valid, stalling only while a digit waits in the output
// register. A new item is accepted only once the previous item's last weight is scanned.
// Reset: synchronous active low on i_rst_n; the block returns to idle with no
// pending result and accepts an item in the first cycle after reset.
module pell_base_digit_converter_top #(
    parameter int NUM_DIGITS = pbdc_pkg::NUM_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pbdc_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pbdc_pkg::DIGIT_W-1:0]  o_digit,
    output logic                          o_last
);

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_DIGITS - 1);
    localparam pbdc_pkg::t_weight W_TOP   = pbdc_pkg::pell_weight(NUM_DIGITS - 1);
    localparam pbdc_pkg::t_weight W_ABOVE = pbdc_pkg::pell_weight(NUM_DIGITS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                          r_state;
    logic [pbdc_pkg::VALUE_W-1:0]  r_rem;
    pbdc_pkg::t_weight             r_w;
    pbdc_pkg::t_weight             r_w_hi;
    logic [POS_W-1:0]              r_pos;
    logic                          r_lead;
    logic                          r_out_valid;
    logic [pbdc_pkg::DIGIT_W-1:0]  r_digit;
    logic                          r_last;

    logic                          in_acc;
    logic                          out_take;
    logic                          step;
    pbdc_pkg::t_weight             rem_ext;
    pbdc_pkg::t_weight             w_dbl;
    pbdc_pkg::t_weight             n_rem_ext;
    logic [pbdc_pkg::DIGIT_W-1:0]  n_digit;
    logic                          emit;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;
    // A weight is scanned only when the output register can take its digit.
    assign step     = (r_state == S_SCAN) && (!r_out_valid || i_ready);

    // Shared compare and subtract unit: twice the weight first, then the weight.
    always_comb begin
        rem_ext = pbdc_pkg::WT_W'(r_rem);
        w_dbl   = {r_w[pbdc_pkg::WT_W-2:0], 1'b0};
        priority if (w_dbl <= rem_ext) begin
            n_digit   = pbdc_pkg::DIGIT_TWO;
            n_rem_ext = rem_ext - w_dbl;
        end else if (r_w <= rem_ext) begin
            n_digit   = pbdc_pkg::DIGIT_ONE;
            n_rem_ext = rem_ext - r_w;
        end else begin
            n_digit   = pbdc_pkg::DIGIT_ZERO;
            n_rem_ext = rem_ext;
        end
        // Leading zeros are dropped, but the lowest weight always gives a digit.
        emit = (n_digit != pbdc_pkg::DIGIT_ZERO) || !r_lead || (r_pos == '0);
    end

    // Sequencer and scan registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lead  <= 1'b1;
            r_pos   <= '0;
        end else if (in_acc) begin
            r_state <= S_SCAN;
            r_lead  <= 1'b1;
            r_pos   <= POS_TOP;
            r_rem   <= i_value;
            r_w     <= W_TOP;
            r_w_hi  <= W_ABOVE;
        end else if (step) begin
            r_rem  <= n_rem_ext[pbdc_pkg::VALUE_W-1:0];
            // Walk the weights downward: P(i-1) = P(i+1) - 2*P(i).
            r_w    <= r_w_hi - w_dbl;
            r_w_hi <= r_w;
            if (emit) begin
                r_lead <= 1'b0;
            end
            if (r_pos == '0) begin
                r_state <= S_IDLE;
            end else begin
                r_pos <= r_pos - 1'b1;
            end
        end
    end

    // Output register holding one digit item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
            r_digit     <= n_digit;
            r_last      <= (r_pos == '0);
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_digit = r_digit;
    assign o_last  = r_last;

endmodule

>>> src/pbdc_checker.sv
module pbdc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [pbdc_pkg::DIGIT_W-1:0]  o_digit,
    input logic                          o_last
);

    // A digit item held back by the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digit) && $stable(o_last))
        else $error("output item changed while stalled");

    // Only base-3 digits are produced.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit == pbdc_pkg::DIGIT_ZERO || o_digit == pbdc_pkg::DIGIT_ONE
                     || o_digit == pbdc_pkg::DIGIT_TWO))
        else $error("digit out of range");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted twice in a row");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("block not idle after reset");

endmodule

bind pell_base_digit_converter_top pbdc_checker u_pbdc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_digit (o_digit),
    .o_last  (o_last)
);
